### design/pds_pkg.sv
// ---------------------------------------------------------------------------
// Pump dry-run supervisor package
// Shared types, codes and fixed-point constants of the supervisor.
// ---------------------------------------------------------------------------
package pds_pkg;

   // Function codes of an input item
   localparam logic [2:0] FUNC_TICK       = 3'd0;
   localparam logic [2:0] FUNC_SET_SPEED  = 3'd1;
   localparam logic [2:0] FUNC_ARM_POUT   = 3'd2;
   localparam logic [2:0] FUNC_READ_CLOG  = 3'd3;
   localparam logic [2:0] FUNC_CLR_TICKS  = 3'd4;

   // Configuration register indexes
   localparam logic [1:0] CSR_DAC_CHANNEL = 2'd0;
   localparam logic [1:0] CSR_NO_POWER    = 2'd1;
   localparam logic [1:0] CSR_DRY_RATIO   = 2'd2;

   // Configuration reset values
   localparam logic [15:0] NO_POWER_RESET  = 16'd560;
   localparam logic [7:0]  DRY_RATIO_RESET = 8'd192;

   // Diagnostic codes
   localparam logic [1:0] DIAG_OFF      = 2'd0;
   localparam logic [1:0] DIAG_OK       = 2'd1;
   localparam logic [1:0] DIAG_DRY_WARN = 2'd2;
   localparam logic [1:0] DIAG_STARTING = 2'd3;

   // Valve commands
   localparam logic [1:0] VALVE_NONE         = 2'd0;
   localparam logic [1:0] VALVE_PINCH        = 2'd1;
   localparam logic [1:0] VALVE_RETURNS_SHUT = 2'd2;

   // Speed limits
   localparam logic [7:0] MAX_SPEED     = 8'd220;
   localparam logic [7:0] RESTART_SPEED = 8'd150;

   // Expected and floor current polynomials, micro-amps
   localparam logic [31:0] E_A = 32'd7155;
   localparam logic [31:0] E_B = 32'd346564;
   localparam logic [31:0] E_C = 32'd28425309;
   localparam logic [31:0] M_A = 32'd4471;
   localparam logic [31:0] M_B = 32'd95061;
   localparam logic [31:0] M_C = 32'd22881203;

   // Scale factors: Q12.4 to micro-amps and the cube-root bound
   localparam logic [31:0] CUR_SCALE  = 32'd256000000;
   localparam logic [31:0] FLOW_SCALE = 32'd62500;
   localparam logic [31:0] ROOT_K     = 32'd1151022592;

   // Tach divider and cube-root search lengths
   localparam int DIV_STEPS = 26;
   localparam int ROOT_BITS = 13;

   // Supervision sequence
   typedef enum logic [2:0] {
      SEQ_RUNNING    = 3'd0,
      SEQ_SENSE_DRY  = 3'd1,
      SEQ_DRAIN      = 3'd2,
      SEQ_STOP_DRAIN = 3'd3,
      SEQ_RESTART    = 3'd4,
      SEQ_MONITOR    = 3'd5
   } seq_type;

   // Estimator sequencer
   typedef enum logic [3:0] {
      EST_IDLE,
      EST_SQ,
      EST_E2,
      EST_E3,
      EST_E4,
      EST_LOW1,
      EST_LOW2,
      EST_M2,
      EST_M3,
      EST_D,
      EST_RHS,
      EST_T1,
      EST_T2,
      EST_T3,
      EST_CMP,
      EST_DONE
   } est_phase_type;

   // Top-level item engine
   typedef enum logic {
      ENG_IDLE,
      ENG_RUN
   } eng_state_type;

   // One accepted item
   typedef struct packed {
      logic [2:0]  func;
      logic [15:0] current_q4;
      logic [15:0] tick_count;
      logic [7:0]  speed_cmd;
   } item_type;

   // Estimator results
   typedef struct packed {
      logic        low;
      logic [15:0] rate;
   } est_result_type;

   // One result item
   typedef struct packed {
      logic [2:0]  seq_state;
      logic [1:0]  diag_code;
      logic        is_running;
      logic        is_dry;
      logic        is_clogged;
      logic        dac_write;
      logic [15:0] dac_frame;
      logic [1:0]  valve_cmd;
      logic [15:0] tach_rate;
      logic [15:0] flow_ticks;
      logic [15:0] flow_rate_q4;
      logic [31:0] flow_total_q4;
   } sup_result_type;

   // Saturating 8-bit increment
   function automatic logic [7:0] inc_sat8(input logic [7:0] v);
      return (v == 8'hFF) ? v : v + 8'd1;
   endfunction

endpackage

### design/pds_divider.sv
// ---------------------------------------------------------------------------
// Tach rate divider
// Restoring divider, one quotient bit per cycle, saturated to 16 bits.
// ---------------------------------------------------------------------------
module pds_divider import pds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [25:0] dividend,
   input  logic [15:0] divisor,
   output logic        busy,
   output logic [15:0] quotient
);

   logic [25:0] quo_ff, quo_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] div_ff, div_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [16:0] rem_sh;
   logic        fits;

   // One shift-subtract step
   assign rem_sh = {rem_ff, quo_ff[25]};
   assign fits   = rem_sh >= {1'b0, div_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = (divisor == 16'd0) ? 16'd1 : divisor;
         cnt_in  = 5'(DIV_STEPS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[24:0], fits};
         rem_in = fits ? 16'(rem_sh - {1'b0, div_ff}) : rem_sh[15:0];
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   // Saturate to the 16-bit rate field
   assign busy     = busy_ff;
   assign quotient = (|quo_ff[25:16]) ? 16'hFFFF : quo_ff[15:0];

endmodule

### design/pds_estimator.sv
// ---------------------------------------------------------------------------
// Current and flow estimator
// One registered 32x32 multiplier under a sequencer evaluates the expected
// and floor current, the dry test and a bitwise exact cube-root search.
// ---------------------------------------------------------------------------
module pds_estimator import pds_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [7:0]     speed,
   input  logic [15:0]    current_q4,
   input  logic [7:0]     dry_ratio,
   output logic           busy,
   output est_result_type result
);

   est_phase_type phase_ff, phase_in;

   logic [7:0]  spd_ff;
   logic [15:0] cur_ff;
   logic [7:0]  ratio_ff;
   logic [63:0] prod_ff;
   logic [15:0] sq_ff;
   logic [31:0] acc_ff;
   logic [47:0] lhs_ff;
   logic [63:0] rhs_ff;
   logic [20:0] t_ff;
   logic [9:0]  t2hi_ff;
   logic [52:0] plo_ff;
   logic [12:0] f_ff;
   logic [3:0]  bit_ff;
   logic        low_ff;

   logic [31:0] mul_a, mul_b;
   logic [31:0] diff_val;
   logic        c_above_m;
   logic [12:0] cand;
   logic [20:0] t_odd;
   logic [20:0] t_val;
   logic [63:0] t3;
   logic        root_ok;

   // Candidate root term t = (2f - 1) * 125
   assign cand     = f_ff | (13'd1 << bit_ff);
   assign t_odd    = {7'd0, cand, 1'b0} - 21'd1;
   assign t_val    = (t_odd << 7) - (t_odd << 1) - t_odd;
   assign t3       = {prod_ff[31:0], 32'd0} + {11'd0, plo_ff};
   assign root_ok  = t3 <= rhs_ff;
   assign diff_val = acc_ff - prod_ff[31:0];
   assign c_above_m = prod_ff[31:0] > acc_ff;

   // Next phase
   always_comb begin
      case (phase_ff)
         EST_IDLE: phase_in = start ? EST_SQ : EST_IDLE;
         EST_SQ:   phase_in = EST_E2;
         EST_E2:   phase_in = EST_E3;
         EST_E3:   phase_in = EST_E4;
         EST_E4:   phase_in = EST_LOW1;
         EST_LOW1: phase_in = EST_LOW2;
         EST_LOW2: phase_in = (spd_ff == 8'd0) ? EST_DONE : EST_M2;
         EST_M2:   phase_in = EST_M3;
         EST_M3:   phase_in = EST_D;
         EST_D:    phase_in = c_above_m ? EST_RHS : EST_DONE;
         EST_RHS:  phase_in = EST_T1;
         EST_T1:   phase_in = EST_T2;
         EST_T2:   phase_in = EST_T3;
         EST_T3:   phase_in = EST_CMP;
         EST_CMP:  phase_in = (bit_ff == 4'd0) ? EST_DONE : EST_T1;
         EST_DONE: phase_in = EST_IDLE;
         default:  phase_in = EST_IDLE;
      endcase
   end

   // Multiplier operands for each phase
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (phase_ff)
         EST_SQ: begin
            mul_a = {24'd0, spd_ff};
            mul_b = {24'd0, spd_ff};
         end
         EST_E2: begin
            mul_a = {16'd0, prod_ff[15:0]};
            mul_b = E_A;
         end
         EST_E3: begin
            mul_a = {24'd0, spd_ff};
            mul_b = E_B;
         end
         EST_E4: begin
            mul_a = diff_val;
            mul_b = {24'd0, ratio_ff};
         end
         EST_LOW1: begin
            mul_a = {16'd0, cur_ff};
            mul_b = CUR_SCALE;
         end
         EST_LOW2: begin
            mul_a = {16'd0, sq_ff};
            mul_b = M_A;
         end
         EST_M2: begin
            mul_a = {24'd0, spd_ff};
            mul_b = M_B;
         end
         EST_M3: begin
            mul_a = {16'd0, cur_ff};
            mul_b = FLOW_SCALE;
         end
         EST_D: begin
            mul_a = prod_ff[31:0] - acc_ff;
            mul_b = ROOT_K;
         end
         EST_T1: begin
            mul_a = {11'd0, t_val};
            mul_b = {11'd0, t_val};
         end
         EST_T2: begin
            mul_a = prod_ff[31:0];
            mul_b = {11'd0, t_ff};
         end
         EST_T3: begin
            mul_a = {22'd0, t2hi_ff};
            mul_b = {11'd0, t_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= EST_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // Shared multiplier and working registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (phase_ff)
         EST_IDLE: begin
            if (start) begin
               spd_ff   <= speed;
               cur_ff   <= current_q4;
               ratio_ff <= dry_ratio;
               f_ff     <= '0;
               bit_ff   <= 4'(ROOT_BITS - 1);
            end
         end
         EST_E2:   sq_ff   <= prod_ff[15:0];
         EST_E3:   acc_ff  <= prod_ff[31:0] + E_C;
         EST_LOW1: lhs_ff  <= {prod_ff[43:0], 4'd0};
         EST_LOW2: low_ff  <= prod_ff[47:0] < lhs_ff;
         EST_M2:   acc_ff  <= prod_ff[31:0] + M_C;
         EST_M3:   acc_ff  <= diff_val;
         EST_RHS:  rhs_ff  <= prod_ff;
         EST_T1:   t_ff    <= t_val;
         EST_T2:   t2hi_ff <= prod_ff[41:32];
         EST_T3:   plo_ff  <= prod_ff[52:0];
         EST_CMP: begin
            if (root_ok) begin
               f_ff <= cand;
            end
            if (bit_ff != 4'd0) begin
               bit_ff <= bit_ff - 4'd1;
            end
         end
         default: begin
         end
      endcase
   end

   assign busy        = phase_ff != EST_IDLE;
   assign result.low  = low_ff;
   assign result.rate = {3'd0, f_ff};

endmodule

### design/pds_supervisor.sv
// ---------------------------------------------------------------------------
// Supervision state
// Holds the sequence, counters, flags and flow totals, and forms the result
// of the pending item; the state advances when the result is loaded.
// ---------------------------------------------------------------------------
module pds_supervisor import pds_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           commit,
   input  item_type       item,
   input  logic [15:0]    tach,
   input  est_result_type est,
   input  logic           dac_channel,
   input  logic [15:0]    no_power_current,
   output logic [7:0]     speed,
   output sup_result_type result
);

   seq_type     seq_ff, seq_in;
   logic [7:0]  step_ff, step_in;
   logic [7:0]  clog_cnt_ff, clog_cnt_in;
   logic [7:0]  dry_cnt_ff, dry_cnt_in;
   logic [7:0]  speed_ff, speed_in;
   logic [7:0]  restart_ff, restart_in;
   logic        en_ff, en_in;
   logic        run_ff, run_in;
   logic        dry_ff, dry_in;
   logic        clog_ff, clog_in;
   logic        pout_ff, pout_in;
   logic [1:0]  diag_ff, diag_in;
   logic [15:0] tach_ff, tach_in;
   logic [15:0] accum_ff, accum_in;
   logic [15:0] rate_ff, rate_in;
   logic [31:0] total_ff, total_in;

   logic        dac_w;
   logic [15:0] dac_f;
   logic [1:0]  valve;
   logic        clog_out;
   logic        nopow;
   logic [32:0] total_sum;

   function automatic logic [15:0] dac_word(input logic ch, input logic [7:0] s);
      return {ch, 2'b00, 1'b1, s, 4'b0000};
   endfunction

   assign nopow     = item.current_q4 < no_power_current;
   assign total_sum = {1'b0, total_ff} + {17'd0, est.rate};

   // Next supervision state for the pending item
   always_comb begin
      logic [7:0] old_step;
      seq_in      = seq_ff;
      step_in     = step_ff;
      clog_cnt_in = clog_cnt_ff;
      dry_cnt_in  = dry_cnt_ff;
      speed_in    = speed_ff;
      restart_in  = restart_ff;
      en_in       = en_ff;
      run_in      = run_ff;
      dry_in      = dry_ff;
      clog_in     = clog_ff;
      pout_in     = pout_ff;
      diag_in     = diag_ff;
      tach_in     = tach_ff;
      accum_in    = accum_ff;
      rate_in     = rate_ff;
      total_in    = total_ff;
      dac_w       = 1'b0;
      dac_f       = '0;
      valve       = VALVE_NONE;
      old_step    = step_ff;

      case (item.func)
         FUNC_TICK: begin
            tach_in  = tach;
            accum_in = accum_ff + item.tick_count;
            if (speed_ff != 8'd0) begin
               rate_in  = est.rate;
               total_in = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
            end
            if (!en_ff) begin
               dry_cnt_in = '0;
               run_in     = 1'b0;
               diag_in    = DIAG_OFF;
            end else begin
               case (seq_ff)
                  // Clog and dry detection
                  SEQ_RUNNING: begin
                     step_in = inc_sat8(step_ff);
                     if (old_step > 8'd3) begin
                        diag_in = DIAG_OK;
                        if (item.tick_count == 16'd0) begin
                           clog_cnt_in = inc_sat8(clog_cnt_ff);
                           if (clog_cnt_in > 8'd4) begin
                              clog_in = 1'b1;
                           end
                        end else begin
                           clog_in = 1'b0;
                        end
                     end
                     if (est.low) begin
                        dry_cnt_in = inc_sat8(dry_cnt_in);
                        if (nopow) begin
                           dac_w = 1'b1;
                           dac_f = dac_word(dac_channel, speed_in);
                        end
                     end else if (dry_cnt_in != 8'd0) begin
                        dry_cnt_in = dry_cnt_in - 8'd1;
                     end
                     if (dry_cnt_in > 8'd5) begin
                        diag_in = DIAG_DRY_WARN;
                        if (dry_cnt_in > 8'd15 && !dry_in) begin
                           seq_in  = SEQ_SENSE_DRY;
                           step_in = '0;
                        end
                     end
                  end
                  // Dry confirmed: stop, then drain or wait to restart
                  SEQ_SENSE_DRY: begin
                     if (pout_ff) begin
                        valve  = VALVE_PINCH;
                        seq_in = SEQ_DRAIN;
                     end else begin
                        dry_in = 1'b1;
                        seq_in = SEQ_RESTART;
                     end
                     speed_in    = '0;
                     dac_w       = 1'b1;
                     dac_f       = dac_word(dac_channel, 8'd0);
                     dry_in      = 1'b0;
                     clog_in     = 1'b0;
                     clog_cnt_in = '0;
                     dry_cnt_in  = '0;
                     run_in      = 1'b0;
                     diag_in     = DIAG_OFF;
                     step_in     = '0;
                  end
                  // Pump-out drain wait, then restart at the fixed speed
                  SEQ_DRAIN: begin
                     step_in = inc_sat8(step_ff);
                     if (old_step > 8'd4) begin
                        restart_in  = RESTART_SPEED;
                        speed_in    = RESTART_SPEED;
                        dac_w       = 1'b1;
                        dac_f       = dac_word(dac_channel, RESTART_SPEED);
                        dry_in      = 1'b0;
                        clog_in     = 1'b0;
                        clog_cnt_in = '0;
                        run_in      = 1'b1;
                        en_in       = 1'b1;
                        diag_in     = DIAG_STARTING;
                        seq_in      = SEQ_STOP_DRAIN;
                        step_in     = '0;
                        dry_cnt_in  = '0;
                     end
                  end
                  // Watch the refill after the drain
                  SEQ_STOP_DRAIN: begin
                     step_in = inc_sat8(step_ff);
                     if (old_step > 8'd3) begin
                        if (est.low) begin
                           diag_in    = DIAG_DRY_WARN;
                           dry_cnt_in = inc_sat8(dry_cnt_ff);
                        end else begin
                           if (dry_cnt_ff != 8'd0) begin
                              dry_cnt_in = dry_cnt_ff - 8'd1;
                           end
                           diag_in = DIAG_OK;
                        end
                        if (step_in > 8'd20 || dry_cnt_in > 8'd5) begin
                           seq_in  = SEQ_RUNNING;
                           step_in = '0;
                           dry_in  = 1'b1;
                           pout_in = 1'b0;
                           valve   = VALVE_RETURNS_SHUT;
                        end
                     end
                  end
                  // Pause, then restart at the remembered speed
                  SEQ_RESTART: begin
                     step_in = inc_sat8(step_ff);
                     if (old_step > 8'd2) begin
                        speed_in    = restart_ff;
                        step_in     = '0;
                        dac_w       = 1'b1;
                        dac_f       = dac_word(dac_channel, restart_ff);
                        dry_in      = 1'b0;
                        clog_in     = 1'b0;
                        clog_cnt_in = '0;
                        dry_cnt_in  = '0;
                        if (restart_ff == 8'd0) begin
                           run_in  = 1'b0;
                           en_in   = 1'b0;
                           diag_in = DIAG_OFF;
                        end else begin
                           run_in  = 1'b1;
                           en_in   = 1'b1;
                           diag_in = DIAG_STARTING;
                        end
                        seq_in = SEQ_MONITOR;
                     end
                  end
                  // Restart monitor: stop again if still dry
                  SEQ_MONITOR: begin
                     step_in = inc_sat8(step_ff);
                     if (old_step > 8'd1) begin
                        if (est.low) begin
                           dry_cnt_in = inc_sat8(dry_cnt_ff);
                           if (nopow) begin
                              dac_w = 1'b1;
                              dac_f = dac_word(dac_channel, speed_ff);
                           end
                        end else if (dry_cnt_ff != 8'd0) begin
                           dry_cnt_in = dry_cnt_ff - 8'd1;
                        end
                        diag_in = est.low ? DIAG_DRY_WARN : DIAG_OK;
                        if (dry_cnt_in > 8'd3) begin
                           speed_in    = '0;
                           step_in     = '0;
                           dac_w       = 1'b1;
                           dac_f       = dac_word(dac_channel, 8'd0);
                           dry_in      = 1'b0;
                           clog_in     = 1'b0;
                           clog_cnt_in = '0;
                           dry_cnt_in  = '0;
                           run_in      = 1'b0;
                           diag_in     = DIAG_OFF;
                           seq_in      = SEQ_RESTART;
                        end
                     end
                  end
                  default: begin
                     seq_in = SEQ_RUNNING;
                  end
               endcase
            end
         end
         // New speed restarts supervision
         FUNC_SET_SPEED: begin
            speed_in    = (item.speed_cmd > MAX_SPEED) ? MAX_SPEED : item.speed_cmd;
            seq_in      = SEQ_RUNNING;
            step_in     = '0;
            dac_w       = 1'b1;
            dac_f       = dac_word(dac_channel, speed_in);
            dry_in      = 1'b0;
            clog_in     = 1'b0;
            clog_cnt_in = '0;
            dry_cnt_in  = '0;
            if (speed_in == 8'd0) begin
               run_in  = 1'b0;
               en_in   = 1'b0;
               pout_in = 1'b0;
               diag_in = DIAG_OFF;
            end else begin
               run_in     = 1'b1;
               en_in      = 1'b1;
               diag_in    = DIAG_STARTING;
               restart_in = speed_in;
               total_in   = '0;
            end
         end
         FUNC_ARM_POUT: begin
            pout_in = 1'b1;
         end
         FUNC_CLR_TICKS: begin
            accum_in = '0;
         end
         default: begin
         end
      endcase

      // The clog flag is reported before a read-clear takes effect
      clog_out = clog_in;
      if (item.func == FUNC_READ_CLOG) begin
         clog_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff      <= SEQ_RUNNING;
         step_ff     <= '0;
         clog_cnt_ff <= '0;
         dry_cnt_ff  <= '0;
         speed_ff    <= '0;
         restart_ff  <= '0;
         en_ff       <= 1'b0;
         run_ff      <= 1'b0;
         dry_ff      <= 1'b0;
         clog_ff     <= 1'b0;
         pout_ff     <= 1'b0;
         diag_ff     <= DIAG_OFF;
         tach_ff     <= '0;
         accum_ff    <= '0;
         rate_ff     <= '0;
         total_ff    <= '0;
      end else if (commit) begin
         seq_ff      <= seq_in;
         step_ff     <= step_in;
         clog_cnt_ff <= clog_cnt_in;
         dry_cnt_ff  <= dry_cnt_in;
         speed_ff    <= speed_in;
         restart_ff  <= restart_in;
         en_ff       <= en_in;
         run_ff      <= run_in;
         dry_ff      <= dry_in;
         clog_ff     <= clog_in;
         pout_ff     <= pout_in;
         diag_ff     <= diag_in;
         tach_ff     <= tach_in;
         accum_ff    <= accum_in;
         rate_ff     <= rate_in;
         total_ff    <= total_in;
      end
   end

   // Result fields
   assign speed                = speed_ff;
   assign result.seq_state     = seq_in;
   assign result.diag_code     = diag_in;
   assign result.is_running    = run_in;
   assign result.is_dry        = dry_in;
   assign result.is_clogged    = clog_out;
   assign result.dac_write     = dac_w;
   assign result.dac_frame     = dac_f;
   assign result.valve_cmd     = valve;
   assign result.tach_rate     = tach_in;
   assign result.flow_ticks    = accum_in;
   assign result.flow_rate_q4  = rate_in;
   assign result.flow_total_q4 = total_in;

endmodule

### design/pump_dry_run_supervisor_unit.sv
// ---------------------------------------------------------------------------
// Pump dry-run supervisor
// Tach rate, flow estimate and dry-run / clog supervision sequence.
// ---------------------------------------------------------------------------
// Usage:
//  The request channel (req_valid / req_stall) carries one command per
//  transfer. The response channel (rsp_valid / rsp_stall) returns exactly
//  one result per command, in order. Configuration registers are written
//  on the csr channel (csr_valid / csr_ready); the user must do so only
//  while no command is pending, which the block does not enforce.
//  csr_ready is always high and writes to unknown indexes are dropped.
//  A command is taken only while the engine is idle; it then stays busy
//  until its result is loaded into the output register, and the next
//  command can transfer in the cycle after that load. A non-tick command
//  needs no arithmetic, so its result is ready once the engine has
//  registered it. A tick's result waits for the 26-step tach divider at
//  speed zero or with the current at or below the floor, and otherwise for
//  the 13 passes of the cube-root search. If the receiver stalls, the next
//  result waits in the engine and the result on the port holds steady.
//  Synchronous reset clears all supervision state, the output valid flag
//  and the configuration registers to their defaults.
// ---------------------------------------------------------------------------
module pump_dry_run_supervisor_unit import pds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [15:0] req_current_q4,
   input  logic [15:0] req_tick_count,
   input  logic [15:0] req_elapsed_ms,
   input  logic [7:0]  req_speed_cmd,
   // Response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_seq_state,
   output logic [1:0]  rsp_diag_code,
   output logic        rsp_is_running,
   output logic        rsp_is_dry,
   output logic        rsp_is_clogged,
   output logic        rsp_dac_write,
   output logic [15:0] rsp_dac_frame,
   output logic [1:0]  rsp_valve_cmd,
   output logic [15:0] rsp_tach_rate,
   output logic [15:0] rsp_flow_ticks,
   output logic [15:0] rsp_flow_rate_q4,
   output logic [31:0] rsp_flow_total_q4,
   // Configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   eng_state_type  eng_ff, eng_in;
   item_type       item_ff;
   logic           dac_channel_ff;
   logic [15:0]    no_power_ff;
   logic [7:0]     dry_ratio_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   sup_result_type rsp_ff;

   logic           req_take;
   logic           tick_start;
   logic [25:0]    scaled_ticks;
   logic           div_busy;
   logic [15:0]    tach;
   logic           est_busy;
   est_result_type est;
   logic [7:0]     speed;
   sup_result_type result;
   logic           finished;
   logic           load;

   // Request transfer and start of the tick arithmetic
   assign req_stall    = eng_ff != ENG_IDLE;
   assign req_take     = req_valid && !req_stall;
   assign tick_start   = req_take && (req_func == FUNC_TICK);
   assign scaled_ticks = ({10'd0, req_tick_count} << 10) - ({10'd0, req_tick_count} << 4)
                         - ({10'd0, req_tick_count} << 3);

   // Result ready once both arithmetic units have settled
   assign finished = (eng_ff == ENG_RUN) && !div_busy && !est_busy;
   assign load     = finished && (!rsp_valid_ff || !rsp_stall);

   pds_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (tick_start),
      .dividend (scaled_ticks),
      .divisor  (req_elapsed_ms),
      .busy     (div_busy),
      .quotient (tach)
   );

   pds_estimator u_estimator (
      .clock      (clock),
      .reset      (reset),
      .start      (tick_start),
      .speed      (speed),
      .current_q4 (req_current_q4),
      .dry_ratio  (dry_ratio_ff),
      .busy       (est_busy),
      .result     (est)
   );

   pds_supervisor u_supervisor (
      .clock            (clock),
      .reset            (reset),
      .commit           (load),
      .item             (item_ff),
      .tach             (tach),
      .est              (est),
      .dac_channel      (dac_channel_ff),
      .no_power_current (no_power_ff),
      .speed            (speed),
      .result           (result)
   );

   // Engine next state
   always_comb begin
      case (eng_ff)
         ENG_IDLE: eng_in = req_take ? ENG_RUN : ENG_IDLE;
         ENG_RUN:  eng_in = load ? ENG_IDLE : ENG_RUN;
         default:  eng_in = ENG_IDLE;
      endcase
   end

   // Output register valid
   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eng_ff       <= ENG_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         eng_ff       <= eng_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take) begin
         item_ff.func       <= req_func;
         item_ff.current_q4 <= req_current_q4;
         item_ff.tick_count <= req_tick_count;
         item_ff.speed_cmd  <= req_speed_cmd;
      end
      if (load) begin
         rsp_ff <= result;
      end
   end

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dac_channel_ff <= 1'b0;
         no_power_ff    <= NO_POWER_RESET;
         dry_ratio_ff   <= DRY_RATIO_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DAC_CHANNEL: dac_channel_ff <= csr_wdata[0];
            CSR_NO_POWER:    no_power_ff    <= csr_wdata;
            CSR_DRY_RATIO:   dry_ratio_ff   <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // Response ports
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_seq_state     = rsp_ff.seq_state;
   assign rsp_diag_code     = rsp_ff.diag_code;
   assign rsp_is_running    = rsp_ff.is_running;
   assign rsp_is_dry        = rsp_ff.is_dry;
   assign rsp_is_clogged    = rsp_ff.is_clogged;
   assign rsp_dac_write     = rsp_ff.dac_write;
   assign rsp_dac_frame     = rsp_ff.dac_frame;
   assign rsp_valve_cmd     = rsp_ff.valve_cmd;
   assign rsp_tach_rate     = rsp_ff.tach_rate;
   assign rsp_flow_ticks    = rsp_ff.flow_ticks;
   assign rsp_flow_rate_q4  = rsp_ff.flow_rate_q4;
   assign rsp_flow_total_q4 = rsp_ff.flow_total_q4;

endmodule

### design/pds_checker.sv
// ---------------------------------------------------------------------------
// Pump dry-run supervisor port checker
// Checks port-level behavior of the supervisor over time.
// ---------------------------------------------------------------------------
module pds_checker import pds_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_dac_write,
   input logic [15:0] rsp_dac_frame,
   input logic [2:0]  rsp_seq_state,
   input logic [1:0]  rsp_valve_cmd
);

   // No result is offered right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   // A command transfer makes the engine busy in the next cycle.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("engine not busy after a command transfer");

   // A stalled result holds.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_dac_frame)
                                    && $stable(rsp_seq_state)))
      else $error("stalled result changed");

   // Without a DAC transfer the frame reads zero.
   a_frame_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_dac_write) |-> (rsp_dac_frame == 16'd0))
      else $error("DAC frame without a DAC write");

   // Sequence and valve codes stay within their defined sets.
   a_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_seq_state <= 3'd5) && (rsp_valve_cmd != 2'd3)))
      else $error("undefined sequence or valve code");

endmodule

bind pump_dry_run_supervisor_unit pds_checker u_pds_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_dac_write (rsp_dac_write),
   .rsp_dac_frame (rsp_dac_frame),
   .rsp_seq_state (rsp_seq_state),
   .rsp_valve_cmd (rsp_valve_cmd)
);

### tb/tb_pump_dry_run_supervisor_unit.sv
// ---------------------------------------------------------------------------
// Pump dry-run supervisor testbench
// Drives commands through the request channel with random gaps and
// response stalls. A behavioral model of the supervisor predicts every
// result, and the monitor compares each field. Configuration changes
// between phases, including the register extremes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pump_dry_run_supervisor_unit;
   import pds_pkg::*;

   localparam int          WATCHDOG_LIMIT   = 3000;
   localparam int          ITEMS_PER_PHASE  = 375;
   localparam int          LONG_HOLD_CYCLES = 300;
   localparam int          SETTLE_CYCLES    = 100;
   localparam logic [2:0]  FUNC_SPARE_FIRST = 3'd5;
   localparam logic [2:0]  FUNC_SPARE_LAST  = 3'd7;

   typedef struct {
      logic [2:0]  func;
      logic [15:0] cur;
      logic [15:0] ticks;
      logic [15:0] ms;
      logic [7:0]  spd;
   } cmd_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_func;
   logic [15:0] req_current_q4;
   logic [15:0] req_tick_count;
   logic [15:0] req_elapsed_ms;
   logic [7:0]  req_speed_cmd;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_seq_state;
   logic [1:0]  rsp_diag_code;
   logic        rsp_is_running;
   logic        rsp_is_dry;
   logic        rsp_is_clogged;
   logic        rsp_dac_write;
   logic [15:0] rsp_dac_frame;
   logic [1:0]  rsp_valve_cmd;
   logic [15:0] rsp_tach_rate;
   logic [15:0] rsp_flow_ticks;
   logic [15:0] rsp_flow_rate_q4;
   logic [31:0] rsp_flow_total_q4;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   pump_dry_run_supervisor_unit u_top (.*);

   // Commands waiting to be driven and results waiting to be seen
   cmd_type        cmd_q[$];
   sup_result_type result_q[$];

   bit failed;
   bit quiet;
   bit long_hold_req;
   bit send_done;
   bit csr_done;
   int gap_cnt;
   int stall_cnt;
   int hold_cnt;
   int idle_cycles;

   // Supervisor model state
   logic        m_chan;
   logic [15:0] m_no_power;
   logic [7:0]  m_ratio;
   logic [2:0]  m_seq;
   logic [7:0]  m_step, m_clog_n, m_dry_n, m_speed, m_restart_speed;
   logic        m_en, m_run, m_dry, m_clog, m_pout;
   logic [1:0]  m_diag;
   logic [15:0] m_tach, m_accum, m_rate;
   logic [31:0] m_total;
   logic        m_dac_w;
   logic [15:0] m_dac_f;

   always #5 clock = ~clock;

   function automatic logic [7:0] sat_inc(input logic [7:0] v);
      return (v == 8'hFF) ? v : v + 8'd1;
   endfunction

   function automatic void send_frame();
      m_dac_w = 1'b1;
      m_dac_f = {m_chan, 2'b00, 1'b1, m_speed, 4'b0000};
   endfunction

   function automatic void clear_supervision();
      m_step = 0;
      send_frame();
      m_clog = 0;
      m_dry = 0;
      m_clog_n = 0;
      m_dry_n = 0;
   endfunction

   function automatic void restart_drive();
      m_speed = m_restart_speed;
      clear_supervision();
      if (m_speed == 0) begin
         m_run = 0;
         m_en = 0;
         m_diag = DIAG_OFF;
      end else begin
         m_run = 1;
         m_en = 1;
         m_diag = DIAG_STARTING;
      end
   endfunction

   function automatic void stop_drive();
      m_speed = 0;
      clear_supervision();
      m_run = 0;
      m_diag = DIAG_OFF;
   endfunction

   function automatic void dry_update(input logic lo, input logic resend);
      if (lo) begin
         m_dry_n = sat_inc(m_dry_n);
         if (resend) send_frame();
      end else if (m_dry_n > 0) begin
         m_dry_n = m_dry_n - 1;
      end
   endfunction

   // Largest f with (2f-1)^3 * 125^3 <= K * d, searched bit by bit
   function automatic logic [15:0] flow_cube_root(input longint unsigned d);
      longint unsigned f, c, t;
      f = 0;
      for (int b = 12; b >= 0; b--) begin
         c = f | (64'd1 << b);
         t = (2 * c - 1) * 125;
         if (t * t * t <= 64'd1151022592 * d) f = c;
      end
      return f[15:0];
   endfunction

   // Periodic tick: tach rate, flow estimate and supervision sequence
   function automatic logic [1:0] run_tick(input cmd_type c);
      longint unsigned q, e_ua, m_ua, c_ua, sum;
      longint          sv;
      logic [15:0]     msv;
      logic [7:0]      prev;
      logic            lo, nopow;
      logic [1:0]      valve;
      valve = VALVE_NONE;
      msv = (c.ms == 0) ? 16'd1 : c.ms;
      q = 64'(c.ticks) * 1000 / 64'(msv);
      m_tach = (q > 65535) ? 16'hFFFF : q[15:0];
      m_accum = m_accum + c.ticks;
      sv = m_speed;
      e_ua = 7155 * sv * sv - 346564 * sv + 28425309;
      lo = (64'(c.cur) * 256000000) < (e_ua * m_ratio * 16);
      nopow = c.cur < m_no_power;
      if (m_speed > 0) begin
         m_ua = 4471 * sv * sv - 95061 * sv + 22881203;
         c_ua = 64'(c.cur) * 62500;
         m_rate = (c_ua > m_ua) ? flow_cube_root(c_ua - m_ua) : 16'd0;
         sum = 64'(m_total) + 64'(m_rate);
         m_total = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
      end
      if (!m_en) begin
         m_dry_n = 0;
         m_run = 0;
         m_diag = DIAG_OFF;
         return valve;
      end
      prev = m_step;
      case (m_seq)
         SEQ_RUNNING: begin
            m_step = sat_inc(m_step);
            if (prev > 3) begin
               m_diag = DIAG_OK;
               if (c.ticks == 0) begin
                  m_clog_n = sat_inc(m_clog_n);
                  if (m_clog_n > 4) m_clog = 1;
               end else begin
                  m_clog = 0;
               end
            end
            dry_update(lo, nopow);
            if (m_dry_n > 5) begin
               m_diag = DIAG_DRY_WARN;
               if (m_dry_n > 15 && !m_dry) begin
                  m_seq = SEQ_SENSE_DRY;
                  m_step = 0;
               end
            end
         end
         SEQ_SENSE_DRY: begin
            if (m_pout) begin
               valve = VALVE_PINCH;
               m_seq = SEQ_DRAIN;
            end else begin
               m_dry = 1;
               m_seq = SEQ_RESTART;
            end
            stop_drive();
            m_step = 0;
         end
         SEQ_DRAIN: begin
            m_step = sat_inc(m_step);
            if (prev > 4) begin
               m_restart_speed = RESTART_SPEED;
               restart_drive();
               m_seq = SEQ_STOP_DRAIN;
               m_step = 0;
               m_dry_n = 0;
            end
         end
         SEQ_STOP_DRAIN: begin
            m_step = sat_inc(m_step);
            if (prev > 3) begin
               if (lo) begin
                  m_diag = DIAG_DRY_WARN;
                  m_dry_n = sat_inc(m_dry_n);
               end else begin
                  if (m_dry_n > 0) m_dry_n = m_dry_n - 1;
                  m_diag = DIAG_OK;
               end
               if (m_step > 20 || m_dry_n > 5) begin
                  m_seq = SEQ_RUNNING;
                  m_step = 0;
                  m_dry = 1;
                  m_pout = 0;
                  valve = VALVE_RETURNS_SHUT;
               end
            end
         end
         SEQ_RESTART: begin
            m_step = sat_inc(m_step);
            if (prev > 2) begin
               restart_drive();
               m_seq = SEQ_MONITOR;
            end
         end
         SEQ_MONITOR: begin
            m_step = sat_inc(m_step);
            if (prev > 1) begin
               dry_update(lo, nopow);
               m_diag = lo ? DIAG_DRY_WARN : DIAG_OK;
               if (m_dry_n > 3) begin
                  stop_drive();
                  m_seq = SEQ_RESTART;
               end
            end
         end
         default: m_seq = SEQ_RUNNING;
      endcase
      return valve;
   endfunction

   // Expected result of one command, advancing the model state
   function automatic sup_result_type predict_cmd(input cmd_type c);
      sup_result_type r;
      logic [1:0]     valve;
      logic [7:0]     s;
      logic           clog_seen;
      valve = VALVE_NONE;
      m_dac_w = 0;
      m_dac_f = 0;
      case (c.func)
         FUNC_TICK: valve = run_tick(c);
         FUNC_SET_SPEED: begin
            s = (c.spd > MAX_SPEED) ? MAX_SPEED : c.spd;
            m_speed = s;
            m_seq = SEQ_RUNNING;
            clear_supervision();
            if (s == 0) begin
               m_run = 0;
               m_en = 0;
               m_pout = 0;
               m_diag = DIAG_OFF;
            end else begin
               m_run = 1;
               m_en = 1;
               m_diag = DIAG_STARTING;
               m_restart_speed = s;
               m_total = 0;
            end
         end
         FUNC_ARM_POUT: m_pout = 1;
         FUNC_CLR_TICKS: m_accum = 0;
         default: ;
      endcase
      clog_seen = m_clog;
      if (c.func == FUNC_READ_CLOG) m_clog = 0;
      r.seq_state     = m_seq;
      r.diag_code     = m_diag;
      r.is_running    = m_run;
      r.is_dry        = m_dry;
      r.is_clogged    = clog_seen;
      r.dac_write     = m_dac_w;
      r.dac_frame     = m_dac_f;
      r.valve_cmd     = valve;
      r.tach_rate     = m_tach;
      r.flow_ticks    = m_accum;
      r.flow_rate_q4  = m_rate;
      r.flow_total_q4 = m_total;
      return r;
   endfunction

   task automatic check_field(input string fname, input longint unsigned exp_v,
                              input longint unsigned act_v);
      if (exp_v !== act_v) begin
         failed = 1;
         $display("%0t: mismatch on %s, expected %0h, got %0h", $time, fname, exp_v, act_v);
      end
   endtask

   // Monitor: model update on request transfers, checks on response transfers
   always @(posedge clock) begin
      sup_result_type e;
      cmd_type        c;
      if (!reset) begin
         idle_cycles++;
         if (req_valid && !req_stall) begin
            c.func = req_func;
            c.cur = req_current_q4;
            c.ticks = req_tick_count;
            c.ms = req_elapsed_ms;
            c.spd = req_speed_cmd;
            result_q.push_back(predict_cmd(c));
            send_done = 1;
            idle_cycles = 0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DAC_CHANNEL: m_chan = csr_wdata[0];
               CSR_NO_POWER:    m_no_power = csr_wdata;
               CSR_DRY_RATIO:   m_ratio = csr_wdata[7:0];
               default: ;
            endcase
            csr_done = 1;
            idle_cycles = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            idle_cycles = 0;
            if (result_q.size() == 0) begin
               failed = 1;
               $display("%0t: result transfer with nothing expected", $time);
            end else begin
               e = result_q.pop_front();
               check_field("seq_state", e.seq_state, rsp_seq_state);
               check_field("diag_code", e.diag_code, rsp_diag_code);
               check_field("is_running", e.is_running, rsp_is_running);
               check_field("is_dry", e.is_dry, rsp_is_dry);
               check_field("is_clogged", e.is_clogged, rsp_is_clogged);
               check_field("dac_write", e.dac_write, rsp_dac_write);
               check_field("dac_frame", e.dac_frame, rsp_dac_frame);
               check_field("valve_cmd", e.valve_cmd, rsp_valve_cmd);
               check_field("tach_rate", e.tach_rate, rsp_tach_rate);
               check_field("flow_ticks", e.flow_ticks, rsp_flow_ticks);
               check_field("flow_rate_q4", e.flow_rate_q4, rsp_flow_rate_q4);
               check_field("flow_total_q4", e.flow_total_q4, rsp_flow_total_q4);
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** pump_dry_run_supervisor_unit: FAILED **");
            $finish;
         end
      end
   end

   // Request driver: one command per transfer, with random gaps between them
   always @(negedge clock) begin
      cmd_type c;
      if (!reset && (!req_valid || send_done)) begin
         send_done = 0;
         if (gap_cnt > 0) begin
            gap_cnt--;
            req_valid <= 1'b0;
         end else if (cmd_q.size() > 0) begin
            c = cmd_q.pop_front();
            req_func <= c.func;
            req_current_q4 <= c.cur;
            req_tick_count <= c.ticks;
            req_elapsed_ms <= c.ms;
            req_speed_cmd <= c.spd;
            req_valid <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0) gap_cnt = $urandom_range(1, 6);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response stall: random bursts, plus one long hold-off on request
   always @(negedge clock) begin
      if (long_hold_req) begin
         long_hold_req = 0;
         hold_cnt = LONG_HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_stall <= 1'b1;
      end else if (stall_cnt > 0) begin
         stall_cnt--;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_cnt = $urandom_range(1, 6) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic add_cmd(input logic [2:0] f, input logic [15:0] cur,
                          input logic [15:0] tk, input logic [15:0] ms,
                          input logic [7:0] spd);
      cmd_type c;
      c.func = f;
      c.cur = cur;
      c.ticks = tk;
      c.ms = ms;
      c.spd = spd;
      cmd_q.push_back(c);
   endtask

   function automatic logic [15:0] pick_current(input int mode);
      case (mode)
         0: return $urandom_range(0, 400);
         1: return $urandom_range(700, 2500);
         2: return $urandom_range(300, 1200);
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   // A speed setting, at times a pump-out arm, then a run of mostly ticks with sticky current levels
   task automatic add_scenario(output int n);
      int         r, mode;
      logic [7:0] spd;
      logic [15:0] tk, ms;
      r = $urandom_range(0, 9);
      if (r == 0) spd = 0;
      else if (r == 1) spd = $urandom_range(221, 255);
      else spd = $urandom_range(1, 220);
      add_cmd(FUNC_SET_SPEED, $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 65535), spd);
      if ($urandom_range(0, 2) == 0)
         add_cmd(FUNC_ARM_POUT, 0, 0, 1, $urandom_range(0, 255));
      n = $urandom_range(8, 50);
      mode = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 7) == 0) mode = $urandom_range(0, 3);
         if ($urandom_range(0, 3) == 0) tk = 0;
         else if ($urandom_range(0, 7) == 0) tk = $urandom_range(0, 65535);
         else tk = $urandom_range(1, 200);
         if ($urandom_range(0, 15) == 0) ms = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
         else ms = $urandom_range(1, 2000);
         if ($urandom_range(0, 11) == 0)
            add_cmd($urandom_range(FUNC_ARM_POUT, FUNC_SPARE_LAST), pick_current(mode), tk,
                    ms, $urandom_range(0, 255));
         else
            add_cmd(FUNC_TICK, pick_current(mode), tk, ms, $urandom_range(0, 255));
      end
      n = n + 1;
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
      @(negedge clock);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      csr_done = 0;
      do @(negedge clock); while (!csr_done);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      wait (cmd_q.size() == 0 && !req_valid && result_q.size() == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic fill_random(input int count);
      int done, n;
      done = 0;
      while (done < count) begin
         add_scenario(n);
         done += n;
      end
   endtask

   initial begin
      clock = 0;
      reset = 1;
      req_valid = 0;
      req_func = FUNC_TICK;
      req_current_q4 = 0;
      req_tick_count = 0;
      req_elapsed_ms = 1;
      req_speed_cmd = 0;
      rsp_stall = 0;
      csr_valid = 0;
      csr_index = CSR_DAC_CHANNEL;
      csr_wdata = 0;
      m_chan = 0;
      m_no_power = NO_POWER_RESET;
      m_ratio = DRY_RATIO_RESET;
      {m_seq, m_step, m_clog_n, m_dry_n, m_speed, m_restart_speed} = '0;
      {m_en, m_run, m_dry, m_clog, m_pout, m_diag} = '0;
      {m_tach, m_accum, m_rate, m_total} = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: field extremes, every function, spare codes, clog read-clear
      add_cmd(FUNC_TICK, 16'hFFFF, 16'hFFFF, 16'd0, 8'hFF);
      add_cmd(FUNC_SET_SPEED, 0, 0, 1, 8'd255);
      add_cmd(FUNC_TICK, 16'd0, 16'd0, 16'd0, 8'd0);
      add_cmd(FUNC_TICK, 16'hFFFF, 16'hFFFF, 16'd1, 8'd0);
      add_cmd(FUNC_TICK, 16'd1000, 16'd100, 16'hFFFF, 8'd0);
      add_cmd(FUNC_ARM_POUT, 0, 0, 1, 8'd0);
      add_cmd(FUNC_CLR_TICKS, 0, 0, 1, 8'd0);
      for (logic [3:0] f = FUNC_SPARE_FIRST; f <= FUNC_SPARE_LAST; f++)
         add_cmd(f[2:0], 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      add_cmd(FUNC_SET_SPEED, 0, 0, 1, 8'd0);
      add_cmd(FUNC_TICK, 16'd500, 16'd10, 16'd100, 8'd0);
      add_cmd(FUNC_SET_SPEED, 0, 0, 1, 8'd1);
      add_cmd(FUNC_TICK, 16'd500, 16'd10, 16'd100, 8'd0);
      add_cmd(FUNC_SET_SPEED, 0, 0, 1, MAX_SPEED);
      for (int i = 0; i < 8; i++) add_cmd(FUNC_TICK, 16'd3000, 16'd0, 16'd1000, 8'd0);
      add_cmd(FUNC_READ_CLOG, 0, 0, 1, 8'd0);
      add_cmd(FUNC_READ_CLOG, 0, 0, 1, 8'd0);

      // Phase with reset configuration
      fill_random(ITEMS_PER_PHASE);
      wait_idle();

      // Channel one, highest thresholds; receiver holds off to back up the block
      write_reg(CSR_DAC_CHANNEL, 16'd1);
      write_reg(CSR_NO_POWER, 16'hFFFF);
      write_reg(CSR_DRY_RATIO, 16'h00FF);
      fill_random(ITEMS_PER_PHASE);
      long_hold_req = 1;
      wait_idle();

      // Lowest thresholds; the sender pauses midway until the block drains
      write_reg(CSR_DAC_CHANNEL, 16'd0);
      write_reg(CSR_NO_POWER, 16'd0);
      write_reg(CSR_DRY_RATIO, 16'd0);
      fill_random(ITEMS_PER_PHASE / 2);
      wait_idle();
      fill_random(ITEMS_PER_PHASE / 2);
      wait_idle();

      // Random configuration, no idling on either side
      write_reg(CSR_DAC_CHANNEL, $urandom_range(0, 1));
      write_reg(CSR_NO_POWER, $urandom_range(0, 2000));
      write_reg(CSR_DRY_RATIO, $urandom_range(0, 255));
      quiet = 1;
      fill_random(ITEMS_PER_PHASE);
      wait_idle();

      if (!failed) begin
         $display("** pump_dry_run_supervisor_unit: PASSED **");
      end else begin
         $display("** pump_dry_run_supervisor_unit: FAILED **");
      end
      $finish;
   end

endmodule
